[rtl/core/assert_macros.svh]
// Assertion helpers. Define ASSERT_OFF to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PPS_ASSERT(lbl, prop, msg)
`define PPS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/core/pps_pkg.sv]
package pps_pkg;

  localparam int ARR_W   = 16;
  localparam int BURST_W = 12;
  localparam int PRIO_W  = 8;
  localparam int PID_W   = 5;
  localparam int RES_W   = 17;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 80;
  localparam int OUT_PAD = OUT_W - PID_W - 4 * RES_W;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arrival;
  } rec_t;

  typedef struct packed {
    logic clear;
    logic vld;
  } scan_ctl_t;

  typedef struct packed {
    logic             found;
    logic [ARR_W-1:0] next_arr;
  } scan_sum_t;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_SCAN = 5'b00010,
    S_UPD  = 5'b00100,
    S_ORD  = 5'b01000,
    S_OLD  = 5'b10000
  } state_t;

endpackage

[rtl/core/pps_ram.sv]
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/pps_scan.sv]
// Shared compare unit: walks the table one entry a cycle and keeps the best
// ready process plus the earliest pending arrival.
module pps_scan #(
  parameter int IDX_W  = 4,
  parameter int TIME_W = 17,
  parameter int DYN_W  = 47
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pps_pkg::scan_ctl_t  ctl,
  input  logic [IDX_W-1:0]    idx,
  input  pps_pkg::rec_t       rec,
  input  logic [DYN_W-1:0]    dyn,
  input  logic [TIME_W-1:0]   cur_time,
  output pps_pkg::scan_sum_t  sum,
  output logic [IDX_W-1:0]    pick_idx,
  output logic [DYN_W-1:0]    pick_dyn
);
  import pps_pkg::*;

  logic               found_r, found_nxt;
  logic [PRIO_W-1:0]  best_r, best_nxt;
  logic [IDX_W-1:0]   pick_r, pick_nxt;
  logic [DYN_W-1:0]   pdyn_r, pdyn_nxt;
  logic [ARR_W-1:0]   next_r, next_nxt;
  logic [BURST_W-1:0] rem;
  logic               live, rdy, better;

  assign rem    = dyn[DYN_W-1 -: BURST_W];
  assign live   = (rem != '0);
  assign rdy    = live && (TIME_W'(rec.arrival) <= cur_time);
  // strict compare keeps the lowest index on a tie
  assign better = rdy && (!found_r || (rec.prio > best_r));

  always_comb begin
    found_nxt = found_r;
    best_nxt  = best_r;
    pick_nxt  = pick_r;
    pdyn_nxt  = pdyn_r;
    next_nxt  = next_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
      next_nxt  = '1;
    end else if (ctl.vld) begin
      if (better) begin
        found_nxt = 1'b1;
        best_nxt  = rec.prio;
        pick_nxt  = idx;
        pdyn_nxt  = dyn;
      end
      if (live && (rec.arrival < next_r)) begin
        next_nxt = rec.arrival;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    best_r <= best_nxt;
    pick_r <= pick_nxt;
    pdyn_r <= pdyn_nxt;
    next_r <= next_nxt;
  end

  assign sum.found    = found_r;
  assign sum.next_arr = next_r;
  assign pick_idx     = pick_r;
  assign pick_dyn     = pdyn_r;

endmodule

[rtl/core/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler. Process records load one beat per cycle into
// a table of MAX_PROCS entries; the beat with tlast, or the one that fills the
// table, starts the run. For each simulated time unit (and each idle jump to the
// next arrival), one compare unit reads the table one entry a cycle, then the
// update state writes the chosen entry. When all processes are done, one result
// beat per process goes out in load order, each once the one before has been
// taken, the final one with tlast. The input is closed from the last record of
// a batch until the final result sits in the output register; a new batch may
// then load while that beat waits.
`include "assert_macros.svh"

module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // arrival_time[15:0], burst_time[27:16], priority_req[35:28], zero pad
  input  logic [pps_pkg::IN_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // process_id[4:0], completion_time[21:5], turnaround_time[38:22],
  // waiting_time[55:39], response_time[72:56], zero pad
  output logic [pps_pkg::OUT_W-1:0] out_tdata,
  output logic                   out_tlast
);
  import pps_pkg::*;

  localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  // latest finish: max arrival plus every burst back to back
  localparam int TIME_W = $clog2(65536 + MAX_PROCS * 4096);
  // dynamic word: remaining, started, first run, completion
  localparam int DYN_W  = BURST_W + 1 + 2 * TIME_W;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    fin_r, fin_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                eval_vld_r, eval_vld_nxt;
  logic [IDX_W-1:0]    eval_idx_r, eval_idx_nxt;
  logic [IDX_W-1:0]    out_i_r, out_i_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_acc;
  rec_t                in_rec;
  logic [BURST_W-1:0]  burst_fix;

  logic                st_we;
  logic [IDX_W-1:0]    st_waddr;
  rec_t                st_rdata;
  logic                dy_we;
  logic [IDX_W-1:0]    dy_waddr;
  logic [DYN_W-1:0]    dy_wdata, dy_rdata;
  logic [IDX_W-1:0]    rd_addr;

  scan_ctl_t           sc_ctl;
  scan_sum_t           sc_sum;
  logic [IDX_W-1:0]    pick_idx;
  logic [DYN_W-1:0]    pick_dyn;
  logic [BURST_W-1:0]  rem_p;
  logic                started_p;
  logic [TIME_W-1:0]   fr_p, fr_new, next_t;

  logic [TIME_W-1:0]   ct, arr_t, tat, wt, rt;
  logic [CNT_W-1:0]    pid_full;
  logic                is_final;

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign in_rec    = rec_t'(in_tdata[ARR_W+BURST_W+PRIO_W-1:0]);
  assign burst_fix = (in_rec.burst == '0) ? BURST_W'(1) : in_rec.burst;

  assign rem_p     = pick_dyn[DYN_W-1 -: BURST_W];
  assign started_p = pick_dyn[2*TIME_W];
  assign fr_p      = pick_dyn[2*TIME_W-1 -: TIME_W];
  assign fr_new    = started_p ? fr_p : time_r;
  assign next_t    = (TIME_W'(sc_sum.next_arr) > time_r) ? TIME_W'(sc_sum.next_arr)
                                                        : time_r + TIME_W'(1);

  assign ct       = dy_rdata[TIME_W-1:0];
  assign arr_t    = TIME_W'(st_rdata.arrival);
  assign tat      = ct - arr_t;
  assign wt       = tat - TIME_W'(st_rdata.burst);
  assign rt       = dy_rdata[2*TIME_W-1 -: TIME_W] - arr_t;
  assign pid_full = CNT_W'(out_i_r) + CNT_W'(1);
  assign is_final = (pid_full == cnt_r);

  assign rd_addr  = (state_r == S_SCAN) ? rd_idx_r[IDX_W-1:0] : out_i_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fin_nxt       = fin_r;
    time_nxt      = time_r;
    rd_idx_nxt    = rd_idx_r;
    eval_vld_nxt  = 1'b0;
    eval_idx_nxt  = rd_idx_r[IDX_W-1:0];
    out_i_nxt     = out_i_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    st_we         = 1'b0;
    st_waddr      = cnt_r[IDX_W-1:0];
    dy_we         = 1'b0;
    dy_waddr      = cnt_r[IDX_W-1:0];
    dy_wdata      = {burst_fix, 1'b0, {(2*TIME_W){1'b0}}};
    sc_ctl.clear  = 1'b0;
    sc_ctl.vld    = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          st_we   = 1'b1;
          dy_we   = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (in_tlast || (cnt_r == CNT_W'(MAX_PROCS - 1))) begin
            state_nxt    = S_SCAN;
            fin_nxt      = '0;
            time_nxt     = '0;
            rd_idx_nxt   = '0;
            sc_ctl.clear = 1'b1;
          end
        end
      end
      S_SCAN: begin
        sc_ctl.vld = eval_vld_r;
        if (rd_idx_r != cnt_r) begin
          eval_vld_nxt = 1'b1;
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
        end else if (!eval_vld_r) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        rd_idx_nxt = '0;
        if (sc_sum.found) begin
          dy_we    = 1'b1;
          dy_waddr = pick_idx;
          dy_wdata = {rem_p - BURST_W'(1), 1'b1, fr_new, time_r + TIME_W'(1)};
          time_nxt = time_r + TIME_W'(1);
          if (rem_p == BURST_W'(1)) begin
            fin_nxt = fin_r + CNT_W'(1);
          end
        end else begin
          time_nxt = next_t;
        end
        if (sc_sum.found && (rem_p == BURST_W'(1)) && (fin_r + CNT_W'(1) == cnt_r)) begin
          state_nxt = S_ORD;
          out_i_nxt = '0;
        end else begin
          state_nxt    = S_SCAN;
          sc_ctl.clear = 1'b1;
        end
      end
      S_ORD: begin
        if (!out_valid_r) begin
          state_nxt = S_OLD;
        end
      end
      S_OLD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {{OUT_PAD{1'b0}}, rt[RES_W-1:0], wt[RES_W-1:0],
                         tat[RES_W-1:0], ct[RES_W-1:0], PID_W'(pid_full)};
        out_last_nxt  = is_final;
        if (is_final) begin
          state_nxt = S_LOAD;
          cnt_nxt   = '0;
          fin_nxt   = '0;
        end else begin
          state_nxt = S_ORD;
          out_i_nxt = out_i_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_LOAD;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      fin_r       <= '0;
      time_r      <= '0;
      rd_idx_r    <= '0;
      eval_vld_r  <= 1'b0;
      out_i_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fin_r       <= fin_nxt;
      time_r      <= time_nxt;
      rd_idx_r    <= rd_idx_nxt;
      eval_vld_r  <= eval_vld_nxt;
      out_i_r     <= out_i_nxt;
      out_valid_r <= out_valid_nxt;
    end
    eval_idx_r <= eval_idx_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  pps_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (MAX_PROCS)
  ) u_static_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata ({in_rec.prio, burst_fix, in_rec.arrival}),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  pps_ram #(
    .WIDTH (DYN_W),
    .DEPTH (MAX_PROCS)
  ) u_dyn_ram (
    .clk   (clk),
    .we    (dy_we),
    .waddr (dy_waddr),
    .wdata (dy_wdata),
    .raddr (rd_addr),
    .rdata (dy_rdata)
  );

  pps_scan #(
    .IDX_W  (IDX_W),
    .TIME_W (TIME_W),
    .DYN_W  (DYN_W)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sc_ctl),
    .idx      (eval_idx_r),
    .rec      (st_rdata),
    .dyn      (dy_rdata),
    .cur_time (time_r),
    .sum      (sc_sum),
    .pick_idx (pick_idx),
    .pick_dyn (pick_dyn)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `PPS_ASSERT(a_load_room, (state_r == S_LOAD) |-> (cnt_r < CNT_W'(MAX_PROCS)), "load with full table")
  `PPS_ASSERT(a_fin_bound, fin_r <= cnt_r, "finished count past entry count")
  `PPS_ASSERT(a_pick_live, ((state_r == S_UPD) && sc_sum.found) |-> (rem_p != '0), "picked a finished process")
  `PPS_ASSERT(a_out_src, $rose(out_valid_r) |-> $past(state_r == S_OLD), "result beat from wrong state")

endmodule

[dv/tb.sv]
module tb;

  localparam int NPROC       = 16;
  localparam int STALL_LIMIT = 400_000;
  localparam int PLAN_ROWS   = 24;
  localparam int RAND_ITEMS  = 76;

  typedef struct packed {
    logic [pps_pkg::PID_W-1:0] pid;
    logic [pps_pkg::RES_W-1:0] completion;
    logic [pps_pkg::RES_W-1:0] turnaround;
    logic [pps_pkg::RES_W-1:0] waiting;
    logic [pps_pkg::RES_W-1:0] response;
    logic                      is_last;
  } sched_res_t;

  // typed = 1 only on single-record batches, whose result is obvious
  typedef struct packed {
    logic [pps_pkg::ARR_W-1:0]   arrival;
    logic [pps_pkg::BURST_W-1:0] burst;
    logic [pps_pkg::PRIO_W-1:0]  prio;
    logic                        lst;
    logic                        typed;
    sched_res_t                  want;
  } plan_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [pps_pkg::IN_W-1:0]  in_tdata;
  logic                      in_tlast;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [pps_pkg::OUT_W-1:0] out_tdata;
  logic                      out_tlast;

  // scheduler model state
  logic [pps_pkg::ARR_W-1:0]   arr_tab  [NPROC];
  logic [pps_pkg::BURST_W-1:0] bst_tab  [NPROC];
  logic [pps_pkg::BURST_W-1:0] left_tab [NPROC];
  logic [pps_pkg::PRIO_W-1:0]  pri_tab  [NPROC];
  int unsigned                 start_tab[NPROC];
  int unsigned                 done_tab [NPROC];
  bit                          began    [NPROC];
  int                          n_loaded = 0;

  sched_res_t due_results[$];
  plan_row_t  plan[PLAN_ROWS];
  int         err_count  = 0;
  int         stall_cnt  = 0;
  bit         steady     = 1'b0;

  preemptive_priority_scheduler #(.MAX_PROCS(NPROC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < 24);
  endfunction

  task automatic log_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [pps_pkg::RES_W-1:0] got_v,
                             input logic [pps_pkg::RES_W-1:0] want_v,
                             input logic [pps_pkg::PID_W-1:0] id);
    if (got_v !== want_v)
      log_mismatch($sformatf("pid %0d %s: got %0d, want %0d", id, what, got_v, want_v));
  endtask

  // Load one record into the model table; on the closing record, run the
  // whole preemptive schedule and queue one result per process.
  function automatic void sched_load(input plan_row_t row);
    int unsigned now, nxt, tat;
    int          pick, best, k, done_cnt;
    sched_res_t  res;
    k = n_loaded;
    arr_tab[k]  = row.arrival;
    bst_tab[k]  = (row.burst == '0) ? 12'd1 : row.burst;
    left_tab[k] = bst_tab[k];
    pri_tab[k]  = row.prio;
    began[k]    = 1'b0;
    n_loaded    = k + 1;
    if (!row.lst && n_loaded < NPROC) return;
    now = 0;
    done_cnt = 0;
    while (done_cnt < n_loaded) begin
      pick = -1;
      best = -1;
      for (int i = 0; i < n_loaded; i++)
        if (arr_tab[i] <= now && left_tab[i] != 0 && int'(pri_tab[i]) > best) begin
          best = int'(pri_tab[i]);
          pick = i;
        end
      if (pick < 0) begin
        // nothing ready: jump to the next arrival
        nxt = 32'hFFFF_FFFF;
        for (int i = 0; i < n_loaded; i++)
          if (left_tab[i] != 0 && arr_tab[i] < nxt) nxt = arr_tab[i];
        now = (nxt > now) ? nxt : now + 1;
      end else begin
        if (!began[pick]) begin
          began[pick]     = 1'b1;
          start_tab[pick] = now;
        end
        left_tab[pick] = left_tab[pick] - 1'b1;
        now++;
        if (left_tab[pick] == 0) begin
          done_tab[pick] = now;
          done_cnt++;
        end
      end
    end
    for (int i = 0; i < n_loaded; i++) begin
      tat            = done_tab[i] - arr_tab[i];
      res.pid        = 5'(i + 1);
      res.completion = 17'(done_tab[i]);
      res.turnaround = 17'(tat);
      res.waiting    = 17'(tat - bst_tab[i]);
      res.response   = 17'(start_tab[i] - arr_tab[i]);
      res.is_last    = (i == n_loaded - 1);
      if (row.typed) due_results.push_back(row.want);
      else due_results.push_back(res);
    end
    n_loaded = 0;
  endfunction

  task automatic send_rec(input plan_row_t row);
    pps_pkg::rec_t            r;
    logic [pps_pkg::IN_W-1:0] word;
    r.arrival = row.arrival;
    r.burst   = row.burst;
    r.prio    = row.prio;
    word      = '0;
    word[$bits(pps_pkg::rec_t)-1:0] = r;
    @(negedge clk);
    while (idle_roll()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tlast  <= row.lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sched_load(row);
  endtask

  // result side: check each beat against the oldest expectation
  always @(posedge clk) begin
    sched_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pid        = out_tdata[pps_pkg::PID_W-1:0];
      got.completion = out_tdata[pps_pkg::PID_W +: pps_pkg::RES_W];
      got.turnaround = out_tdata[pps_pkg::PID_W + pps_pkg::RES_W +: pps_pkg::RES_W];
      got.waiting    = out_tdata[pps_pkg::PID_W + 2 * pps_pkg::RES_W +: pps_pkg::RES_W];
      got.response   = out_tdata[pps_pkg::PID_W + 3 * pps_pkg::RES_W +: pps_pkg::RES_W];
      got.is_last    = out_tlast;
      if (due_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result beat, pid %0d", got.pid));
      end else begin
        want = due_results.pop_front();
        check_field("process_id", 17'(got.pid), 17'(want.pid), want.pid);
        check_field("completion_time", got.completion, want.completion, want.pid);
        check_field("turnaround_time", got.turnaround, want.turnaround, want.pid);
        check_field("waiting_time", got.waiting, want.waiting, want.pid);
        check_field("response_time", got.response, want.response, want.pid);
        check_field("tlast", 17'(got.is_last), 17'(want.is_last), want.pid);
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_tready <= !idle_roll();
    end
  end

  initial begin
    plan_row_t row;
    int        sz, loaded, batch_no;
    bit        wide;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    plan = '{
      // single records: result readable at a glance
      '{16'd0,     12'd1,    8'd0,   1'b1, 1'b1, '{5'd1, 17'd1,     17'd1,    17'd0, 17'd0, 1'b1}},
      '{16'hFFFF,  12'hFFF,  8'hFF,  1'b1, 1'b1, '{5'd1, 17'd69630, 17'd4095, 17'd0, 17'd0, 1'b1}},
      // zero burst runs as one unit
      '{16'd100,   12'd0,    8'd7,   1'b1, 1'b1, '{5'd1, 17'd101,   17'd1,    17'd0, 17'd0, 1'b1}},
      // later, higher priority arrivals preempt
      '{16'd0,     12'd5,    8'd1,   1'b0, 1'b0, '0},
      '{16'd2,     12'd2,    8'd9,   1'b0, 1'b0, '0},
      '{16'd3,     12'd1,    8'd9,   1'b1, 1'b0, '0},
      // idle stretch between arrivals
      '{16'd10,    12'd2,    8'd0,   1'b0, 1'b0, '0},
      '{16'd50,    12'd3,    8'd200, 1'b1, 1'b0, '0},
      // sixteen records, no tlast: the full table closes the batch
      '{16'd0,     12'd3,    8'd4,   1'b0, 1'b0, '0},
      '{16'd0,     12'd3,    8'd4,   1'b0, 1'b0, '0},
      '{16'hAAAA,  12'd2,    8'hAA,  1'b0, 1'b0, '0},
      '{16'h5555,  12'd1,    8'h55,  1'b0, 1'b0, '0},
      '{16'd5,     12'd20,   8'h80,  1'b0, 1'b0, '0},
      '{16'd1,     12'd4,    8'h80,  1'b0, 1'b0, '0},
      '{16'd7,     12'd1,    8'hFF,  1'b0, 1'b0, '0},
      '{16'd7,     12'd1,    8'hFF,  1'b0, 1'b0, '0},
      '{16'd30,    12'd6,    8'h01,  1'b0, 1'b0, '0},
      '{16'd31,    12'd2,    8'h02,  1'b0, 1'b0, '0},
      '{16'h0F0F,  12'd3,    8'h0F,  1'b0, 1'b0, '0},
      '{16'hF0F0,  12'd5,    8'hF0,  1'b0, 1'b0, '0},
      '{16'd12,    12'd0,    8'h33,  1'b0, 1'b0, '0},
      '{16'd3,     12'd9,    8'hCC,  1'b0, 1'b0, '0},
      '{16'd2,     12'd2,    8'h80,  1'b0, 1'b0, '0},
      '{16'h8000,  12'd7,    8'h00,  1'b0, 1'b0, '0}
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) send_rec(plan[i]);

    loaded   = 0;
    batch_no = 0;
    while (loaded < RAND_ITEMS) begin
      steady = (batch_no >= 4 && batch_no < 8);
      sz     = ($urandom_range(9) == 0) ? NPROC : $urandom_range(1, 6);
      wide   = ($urandom_range(3) == 0);
      for (int j = 0; j < sz; j++) begin
        row         = '0;
        row.arrival = wide ? 16'($urandom) : 16'($urandom_range(40));
        row.burst   = ($urandom_range(9) == 0) ? 12'($urandom_range(255))
                                               : 12'($urandom_range(15));
        row.prio    = ($urandom_range(1) == 1) ? 8'($urandom) : 8'($urandom_range(3));
        // a full batch sometimes closes on the table filling up alone
        row.lst     = (j == sz - 1) && !(sz == NPROC && $urandom_range(1) == 1);
        send_rec(row);
        loaded++;
      end
      batch_no++;
    end
    steady = 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
